@@ src/obms_pkg.sv @@
// shared types and constants for the oversampled button mode stepper
package obms_pkg;

    // default width of the window and need counters
    localparam int WINDOW_BITS_DEF = 16;

    // configuration register geometry
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_WIN_BITS  = 16;
    localparam int MODE_BITS     = 4;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_PRESS_WINDOW   = 2'd0;
    localparam logic [1:0] REG_RELEASE_WINDOW = 2'd1;
    localparam logic [1:0] REG_TOP_MODE       = 2'd2;

    // reset values of the registers
    localparam logic [CFG_WIN_BITS-1:0] PRESS_WINDOW_RST   = 16'd50;
    localparam logic [CFG_WIN_BITS-1:0] RELEASE_WINDOW_RST = 16'd50;
    localparam logic [MODE_BITS-1:0]    TOP_MODE_RST       = 4'd3;

    // debounce phase codes
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_ARMED     = 2'd1;
    localparam logic [1:0] PH_SAMPLING  = 2'd2;
    localparam logic [1:0] PH_QUALIFIED = 2'd3;

    // one tick word
    typedef struct packed {
        logic pin_changed;
        logic switch_level;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic [MODE_BITS-1:0] light_mode;
        logic                 mode_stepped;
        logic [1:0]           debounce_phase;
    } t_out_word;

    // configuration handed to the core
    typedef struct packed {
        logic [CFG_WIN_BITS-1:0] press_window;
        logic [CFG_WIN_BITS-1:0] release_window;
        logic [MODE_BITS-1:0]    top_mode;
    } t_cfg;

endpackage

@@ src/obms_cfg.sv @@
// apb configuration registers of the mode stepper
module obms_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [obms_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [obms_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [obms_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output obms_pkg::t_cfg                      o_cfg
);
    import obms_pkg::*;

    logic [CFG_WIN_BITS-1:0] r_press_window;
    logic [CFG_WIN_BITS-1:0] r_release_window;
    logic [MODE_BITS-1:0]    r_top_mode;
    logic                    wr_en;
    logic [1:0]              reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_window   <= PRESS_WINDOW_RST;
            r_release_window <= RELEASE_WINDOW_RST;
            r_top_mode       <= TOP_MODE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PRESS_WINDOW:   r_press_window   <= pwdata[CFG_WIN_BITS-1:0];
                REG_RELEASE_WINDOW: r_release_window <= pwdata[CFG_WIN_BITS-1:0];
                REG_TOP_MODE:       r_top_mode       <= pwdata[MODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_PRESS_WINDOW:
                prdata = {{(CFG_DATA_BITS-CFG_WIN_BITS){1'b0}}, r_press_window};
            REG_RELEASE_WINDOW:
                prdata = {{(CFG_DATA_BITS-CFG_WIN_BITS){1'b0}}, r_release_window};
            REG_TOP_MODE:
                prdata = {{(CFG_DATA_BITS-MODE_BITS){1'b0}}, r_top_mode};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg.press_window   = r_press_window;
    assign o_cfg.release_window = r_release_window;
    assign o_cfg.top_mode       = r_top_mode;

endmodule

@@ src/obms_core.sv @@
// debounce state, mode counter and result register
module obms_core #(
    parameter int WINDOW_BITS = obms_pkg::WINDOW_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  obms_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  obms_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output obms_pkg::t_out_word o_out_word
);
    import obms_pkg::*;

    logic [1:0]             r_phase, n_phase;
    logic                   r_expect, n_expect;
    logic [WINDOW_BITS-1:0] r_window, n_window;
    logic [WINDOW_BITS-1:0] r_need, n_need;
    logic [MODE_BITS-1:0]   r_mode, n_mode;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    logic                   in_acc;
    logic                   stepped;
    logic [31:0]            load_wide;
    logic [MODE_BITS:0]     mode_inc;
    logic                   agrees;

    // a new word enters unless the result register is full and held
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign agrees   = i_in_word.switch_level ^ r_expect;
    assign mode_inc = {1'b0, r_mode} + {{MODE_BITS{1'b0}}, 1'b1};

    // next debounce state for one tick
    always_comb begin
        n_phase   = r_phase;
        n_expect  = r_expect;
        n_window  = r_window;
        n_need    = r_need;
        n_mode    = r_mode;
        stepped   = 1'b0;
        load_wide = '0;
        unique case (r_phase)
            PH_ARMED: begin
                n_phase   = PH_SAMPLING;
                n_expect  = !r_expect;
                load_wide = {16'd0, (!r_expect) ? i_cfg.press_window
                                                : i_cfg.release_window};
                n_window  = load_wide[WINDOW_BITS-1:0];
                // need is half of the window after truncation
                n_need    = n_window >> 1;
            end
            PH_SAMPLING: begin
                if (r_window != '0) begin
                    n_window = r_window - 1'b1;
                    if (r_need != '0 && agrees) begin
                        n_need = r_need - 1'b1;
                    end
                end else if (r_need != '0) begin
                    n_phase  = PH_IDLE;
                    n_need   = '0;
                    n_window = '0;
                end else begin
                    n_phase = PH_QUALIFIED;
                end
            end
            PH_QUALIFIED: begin
                n_phase = PH_IDLE;
                if (r_expect) begin
                    stepped = 1'b1;
                    if (mode_inc > {1'b0, i_cfg.top_mode}) begin
                        n_mode   = '0;
                        n_expect = 1'b0;
                    end else begin
                        n_mode = mode_inc[MODE_BITS-1:0];
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        // arming looks at the phase after the step
        if (i_in_word.pin_changed && n_phase == PH_IDLE) begin
            n_phase = PH_ARMED;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_expect <= 1'b0;
            r_window <= '0;
            r_need   <= '0;
            r_mode   <= '0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_expect <= n_expect;
            r_window <= n_window;
            r_need   <= n_need;
            r_mode   <= n_mode;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_word.light_mode     <= n_mode;
            r_out_word.mode_stepped   <= stepped;
            r_out_word.debounce_phase <= n_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ src/oversampled_button_mode_stepper.sv @@
// top level of the oversampled button mode stepper
// One input word is one 1 ms tick with a pin-change flag and the raw switch
// level (0 pressed, 1 released). Each tick gives exactly one result word with
// the mode number, a stepped flag and the debounce phase. The block takes a
// tick every clock cycle unless the result register is full and held; the
// result is in the output register in the cycle after the tick is taken,
// and a new tick is taken while that result waits as long as it is taken
// in the same cycle. The core's state update sets the rate. Window registers
// are 16 bits, truncated or zero-extended to WINDOW_BITS on load. The user
// must write configuration only while no tick is in flight; not enforced.
module oversampled_button_mode_stepper #(
    parameter int WINDOW_BITS = obms_pkg::WINDOW_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [obms_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [obms_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [obms_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  obms_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output obms_pkg::t_out_word                 o_out_word
);
    import obms_pkg::*;

    t_cfg cfg;

    // configuration registers
    obms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // debounce and mode logic
    obms_core #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

@@ tb/oversampled_button_mode_stepper_tb.sv @@
// self-checking testbench for the oversampled button mode stepper
module oversampled_button_mode_stepper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import obms_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 8;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr   = '0;
    logic [CFG_DATA_BITS-1:0] pwdata  = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_in_word                 i_in_word = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_word                o_out_word;

    // local copy of the registers
    logic [CFG_WIN_BITS-1:0] cfg_press_win   = PRESS_WINDOW_RST;
    logic [CFG_WIN_BITS-1:0] cfg_release_win = RELEASE_WINDOW_RST;
    logic [MODE_BITS-1:0]    cfg_top         = TOP_MODE_RST;

    // debouncer state as the block should hold it
    logic [1:0]              db_phase    = PH_IDLE;
    logic                    exp_pressed = 1'b0;
    logic [CFG_WIN_BITS-1:0] win_left    = '0;
    logic [CFG_WIN_BITS-1:0] need_left   = '0;
    logic [MODE_BITS-1:0]    mode_num    = '0;

    // status words still to come out of the block
    t_out_word status_q[$];

    int          error_count   = 0;
    int unsigned ticks_sent    = 0;
    int unsigned words_checked = 0;
    int unsigned mode_steps    = 0;
    int unsigned qualified_cnt = 0;
    int unsigned failed_cnt    = 0;
    int unsigned quiet_cycles  = 0;

    // traffic shaping knobs
    bit          gaps_on      = 1'b1;
    bit          stall_on     = 1'b1;
    int unsigned burst_left   = 0;
    logic        hold_request = 1'b0;
    logic        hold_req_q   = 1'b0;
    int unsigned hold_left    = 0;
    logic        stall_level  = 1'b0;
    int unsigned stall_run    = 0;

    oversampled_button_mode_stepper u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit log_failure();
        error_count++;
        return error_count <= REPORT_LIMIT;
    endfunction

    // one tick of the debouncer: advance the state, return the status word
    function automatic t_out_word debounce_tick(t_in_word w);
        t_out_word  r;
        logic [4:0] next_mode;
        logic       stepped;
        logic       agrees;
        stepped = 1'b0;
        case (db_phase)
            PH_ARMED: begin
                db_phase    = PH_SAMPLING;
                exp_pressed = ~exp_pressed;
                win_left    = exp_pressed ? cfg_press_win : cfg_release_win;
                need_left   = win_left >> 1;
            end
            PH_SAMPLING: begin
                if (win_left != 0) begin
                    win_left = win_left - 1'b1;
                    agrees   = exp_pressed ? ~w.switch_level : w.switch_level;
                    if (need_left != 0 && agrees)
                        need_left = need_left - 1'b1;
                end else if (need_left != 0) begin
                    db_phase  = PH_IDLE;
                    need_left = '0;
                    win_left  = '0;
                    failed_cnt++;
                end else begin
                    db_phase = PH_QUALIFIED;
                    qualified_cnt++;
                end
            end
            PH_QUALIFIED: begin
                db_phase = PH_IDLE;
                if (exp_pressed) begin
                    next_mode = {1'b0, mode_num} + 5'd1;
                    stepped   = 1'b1;
                    mode_steps++;
                    // past the top the mode wraps and the position is forced released
                    if (next_mode > {1'b0, cfg_top}) begin
                        next_mode   = '0;
                        exp_pressed = 1'b0;
                    end
                    mode_num = next_mode[MODE_BITS-1:0];
                end
            end
            default: db_phase = PH_IDLE;
        endcase
        // arming looks at the phase after the step, so a fresh idle re-arms
        if (w.pin_changed && db_phase == PH_IDLE)
            db_phase = PH_ARMED;
        r.light_mode     = mode_num;
        r.mode_stepped   = stepped;
        r.debounce_phase = db_phase;
        return r;
    endfunction

    // offer one tick word and wait until it is taken
    task automatic send_tick(input logic changed, input logic level);
        t_in_word w;
        int       gap;
        w.pin_changed  = changed;
        w.switch_level = level;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left != 0)
            burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        status_q.push_back(debounce_tick(w));
        ticks_sent++;
    endtask

    // stop sending and wait for every status word to come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register access, setup then access cycle; reads are checked
    task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
        logic [CFG_DATA_BITS-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        want = '0;
        case (idx)
            REG_PRESS_WINDOW: begin
                if (wr) cfg_press_win = data[CFG_WIN_BITS-1:0];
                want[CFG_WIN_BITS-1:0] = cfg_press_win;
            end
            REG_RELEASE_WINDOW: begin
                if (wr) cfg_release_win = data[CFG_WIN_BITS-1:0];
                want[CFG_WIN_BITS-1:0] = cfg_release_win;
            end
            default: begin
                if (wr) cfg_top = data[MODE_BITS-1:0];
                want[MODE_BITS-1:0] = cfg_top;
            end
        endcase
        if (!wr && prdata !== want && log_failure())
            $display("register %0d read: expected %0h, got %0h", idx, want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus idle between transfers
        @(posedge i_clk);
    endtask

    // new settings once the block is quiet, each register read back
    task automatic set_config(input int press_win, input int release_win, input int top);
        drain_results();
        apb_transfer(1'b1, REG_PRESS_WINDOW, press_win);
        apb_transfer(1'b1, REG_RELEASE_WINDOW, release_win);
        apb_transfer(1'b1, REG_TOP_MODE, top);
        apb_transfer(1'b0, REG_PRESS_WINDOW, '0);
        apb_transfer(1'b0, REG_RELEASE_WINDOW, '0);
        apb_transfer(1'b0, REG_TOP_MODE, '0);
    endtask

    // a pin change, then samples until the debouncer is idle again or the cap is reached
    task automatic button_gesture(input int agree_pct, input int noise_pct, input int cap);
        int   n;
        logic lvl;
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        n = 0;
        while (db_phase != PH_IDLE && n < cap) begin
            lvl = exp_pressed ? 1'b0 : 1'b1;
            if ($urandom_range(99) >= agree_pct)
                lvl = ~lvl;
            send_tick($urandom_range(99) < noise_pct, lvl);
            n++;
        end
    endtask

    task automatic test_reset_values();
        apb_transfer(1'b0, REG_PRESS_WINDOW, '0);
        apb_transfer(1'b0, REG_RELEASE_WINDOW, '0);
        apb_transfer(1'b0, REG_TOP_MODE, '0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    // zero windows qualify at once; wrap past the top; re-arm on the idle tick
    task automatic test_zero_window();
        set_config(0, 0, 1);
        button_gesture(100, 0, 8);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        button_gesture(100, 0, 8);
    endtask

    // unmet need drops back to idle, and a pin change there re-arms at once
    task automatic test_failed_window();
        set_config(4, 4, 15);
        button_gesture(0, 0, 12);
        button_gesture(0, 100, 6);
        button_gesture(100, 0, 12);
    endtask

    // top lowered under the current mode, then a top of zero
    task automatic test_top_below_mode();
        int unsigned steps_at_start;
        set_config(0, 0, 15);
        for (int g = 0; g < 16 && mode_num < 3; g++)
            button_gesture(100, 0, 8);
        set_config(0, 0, 1);
        steps_at_start = mode_steps;
        for (int g = 0; g < 6 && mode_steps == steps_at_start; g++)
            button_gesture(100, 0, 8);
        set_config(0, 0, 0);
        for (int g = 0; g < 4; g++)
            button_gesture(100, 0, 8);
    endtask

    // long receiver hold-off while ticks keep coming back to back
    task automatic test_output_holdoff();
        set_config(3, 2, 7);
        gaps_on = 1'b0;
        hold_request <= 1'b1;
        for (int k = 0; k < 8; k++)
            button_gesture(95, 10, 20);
        hold_request <= 1'b0;
        gaps_on = 1'b1;
    endtask

    // mostly well-formed gestures with random content, some broken, some noise
    task automatic test_random_gestures();
        int unsigned quota;
        int          agree;
        int          press_win;
        int          release_win;
        int          top;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            press_win   = (p == 0) ? PRESS_WINDOW_RST :
                          (p == 1) ? $urandom_range(0, 2) : $urandom_range(0, 10);
            release_win = (p == 0) ? RELEASE_WINDOW_RST :
                          (p == 1) ? $urandom_range(0, 2) : $urandom_range(0, 10);
            top         = (p == 0) ? TOP_MODE_RST : (p == 1) ? 15 : (p == 2) ? 1 :
                          (p == 3) ? 0 : $urandom_range(1, 15);
            set_config(press_win, release_win, top);
            gaps_on  = (p % 3 != 2);
            stall_on = (p % 4 != 3);
            quota    = ticks_sent + ((p == 1) ? 150 : 80);
            while (ticks_sent < quota) begin
                if ($urandom_range(9) == 0) begin
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else begin
                    agree = ($urandom_range(99) < 85) ? $urandom_range(90, 100)
                                                      : $urandom_range(0, 60);
                    button_gesture(agree, 5, 120);
                end
            end
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // the widest window the registers allow, loaded and sampled for a stretch
    task automatic test_widest_window();
        set_config(16'hFFFF, 16'hFFFF, 15);
        button_gesture(60, 5, 40);
    endtask

    // receiver stall: one long hold-off on request, else a random on/off pattern, or none with stall_on off
    always @(posedge i_clk) begin
        hold_req_q <= hold_request;
        if (hold_request && !hold_req_q) begin
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!stall_on) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_level = ~stall_level;
                stall_run   = stall_level ? $urandom_range(1, 5) : $urandom_range(1, 16);
            end else begin
                stall_run--;
            end
            i_out_stall <= stall_level;
        end
    end

    // compare each status word with the oldest prediction
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                if (log_failure())
                    $display("unexpected status word: mode %0d stepped %0b phase %0d",
                             o_out_word.light_mode, o_out_word.mode_stepped,
                             o_out_word.debounce_phase);
            end else begin
                want = status_q.pop_front();
                words_checked++;
                if (o_out_word.light_mode !== want.light_mode ||
                    o_out_word.mode_stepped !== want.mode_stepped ||
                    o_out_word.debounce_phase !== want.debounce_phase) begin
                    if (log_failure())
                        $display("word %0d: expected mode %0d stepped %0b phase %0d, got mode %0d stepped %0b phase %0d",
                                 words_checked, want.light_mode, want.mode_stepped,
                                 want.debounce_phase, o_out_word.light_mode,
                                 o_out_word.mode_stepped, o_out_word.debounce_phase);
                end
            end
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_zero_window();
        test_failed_window();
        test_top_below_mode();
        test_output_holdoff();
        test_random_gestures();
        test_widest_window();
        drain_results();
        repeat (8) @(posedge i_clk);
        $display("sent %0d ticks and checked %0d status words across zero, reset and widest windows",
                 ticks_sent, words_checked);
        $display("debounce windows qualified %0d, failed %0d; mode steps %0d, tops 0 to 15",
                 qualified_cnt, failed_cnt, mode_steps);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ oversampled_button_mode_stepper.f @@
src/obms_pkg.sv
src/obms_cfg.sv
src/obms_core.sv
src/oversampled_button_mode_stepper.sv
tb/oversampled_button_mode_stepper_tb.sv
